/* rtl/caf_pkg.sv */
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and constants of the cell address formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package caf_pkg;

  localparam int MAX_ROWS      = 1048576;
  localparam int MAX_COLS      = 16384;
  localparam int ALPHA         = 26;
  localparam int LETTER_BASE   = 64;
  localparam int THREE_LETTERS = 703;
  localparam int RADIX         = 10;
  localparam int DIGIT_BASE    = 48;

  localparam int IN_ROW_W = 24;
  localparam int IN_COL_W = 16;
  localparam int ROW_W    = 21;
  localparam int COL_W    = 15;
  localparam int CHAR_W   = 7;

  // source width shifted through both converters, one bit a cycle
  localparam int CONV_W = ROW_W;
  localparam int V_W    = 14;

  localparam int LET_DIGITS = 3;
  localparam int LET_W      = 5;
  localparam int DEC_DIGITS = 7;
  localparam int DEC_W      = 4;
  localparam int LET_VW     = LET_DIGITS * LET_W;
  localparam int DEC_VW     = DEC_DIGITS * DEC_W;
  localparam int NLET_W     = 2;
  localparam int NDEC_W     = 3;

  typedef struct packed {
    logic [IN_ROW_W-1:0] row_number;
    logic [IN_COL_W-1:0] column_number;
  } cell_t;

  typedef struct packed {
    logic [CHAR_W-1:0] address_char;
    logic              last_char;
    logic [ROW_W-1:0]  row_used;
    logic [COL_W-1:0]  column_used;
  } addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CONV,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic [NLET_W-1:0] n_let;
    logic [NDEC_W-1:0] n_dec;
  } emit_ctrl_t;

endpackage

`default_nettype wire

/* rtl/cell_address_formatter.sv */
// Sequence: accept, a prep state, a conversion state (shifting in the row bits one
// at a time through the bit-serial converters), a load state, then one character
// per cycle while the output is not stalled. A new item is taken only once the
// last one has been emitted in full; an address is 2 to 10 characters long.
// A finished character waits in the output register while the next item is taken.
// Reset: synchronous, active high; clears the sequencer, counters and output valid.
// ----------------------------------------------------------------------------
// cell_address_formatter
// Clamps row and column, converts them bit-serially to base 26 and base 10
// and streams the A1-style address one character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_address_formatter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cell_valid,
  output logic                cell_ready,
  input  wire caf_pkg::cell_t cell_data,
  output logic                addr_valid,
  input  wire logic           addr_ready,
  output caf_pkg::addr_t      addr
);

  localparam int CNT_W = $clog2(caf_pkg::CONV_W);

  caf_pkg::state_t             state, state_next;
  logic [CNT_W-1:0]            cnt;
  logic [caf_pkg::ROW_W-1:0]   row_c;
  logic [caf_pkg::COL_W-1:0]   col_c;
  logic [caf_pkg::ROW_W-1:0]   row_clamp;
  logic [caf_pkg::COL_W-1:0]   col_clamp;
  logic [caf_pkg::V_W-1:0]     col_v;
  logic [caf_pkg::NLET_W-1:0]  n_let;
  logic [caf_pkg::NDEC_W-1:0]  n_dec;
  logic [caf_pkg::NLET_W-1:0]  n_let_r;
  logic [caf_pkg::NDEC_W-1:0]  n_dec_r;
  logic [caf_pkg::LET_VW-1:0]  letters;
  logic [caf_pkg::DEC_VW-1:0]  decimals;
  logic                        conv_start;
  logic                        conv_step;
  logic                        emit_active;
  caf_pkg::emit_ctrl_t         ctrl;

  // clamping of the incoming beat
  always_comb begin
    if (cell_data.row_number == '0) begin
      row_clamp = caf_pkg::ROW_W'(1);
    end else if (cell_data.row_number > caf_pkg::IN_ROW_W'(caf_pkg::MAX_ROWS)) begin
      row_clamp = caf_pkg::ROW_W'(caf_pkg::MAX_ROWS);
    end else begin
      row_clamp = cell_data.row_number[caf_pkg::ROW_W-1:0];
    end
    if (cell_data.column_number == '0) begin
      col_clamp = caf_pkg::COL_W'(1);
    end else if (cell_data.column_number > caf_pkg::IN_COL_W'(caf_pkg::MAX_COLS)) begin
      col_clamp = caf_pkg::COL_W'(caf_pkg::MAX_COLS);
    end else begin
      col_clamp = cell_data.column_number[caf_pkg::COL_W-1:0];
    end
  end

  // letter count, offset column and decimal digit count
  always_comb begin
    int p;
    if (col_c <= caf_pkg::COL_W'(caf_pkg::ALPHA)) begin
      n_let = caf_pkg::NLET_W'(1);
      col_v = caf_pkg::V_W'(col_c - caf_pkg::COL_W'(1));
    end else if (col_c < caf_pkg::COL_W'(caf_pkg::THREE_LETTERS)) begin
      n_let = caf_pkg::NLET_W'(2);
      col_v = caf_pkg::V_W'(col_c - caf_pkg::COL_W'(caf_pkg::ALPHA + 1));
    end else begin
      n_let = caf_pkg::NLET_W'(3);
      col_v = caf_pkg::V_W'(col_c - caf_pkg::COL_W'(caf_pkg::THREE_LETTERS));
    end
    n_dec = caf_pkg::NDEC_W'(1);
    p = caf_pkg::RADIX;
    for (int i = 1; i < caf_pkg::DEC_DIGITS; i++) begin
      if (row_c >= caf_pkg::ROW_W'(p)) begin
        n_dec = caf_pkg::NDEC_W'(i + 1);
      end
      p = p * caf_pkg::RADIX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= caf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == caf_pkg::ST_CONV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid && cell_ready) begin
      row_c <= row_clamp;
      col_c <= col_clamp;
    end
    if (state == caf_pkg::ST_PREP) begin
      n_let_r <= n_let;
      n_dec_r <= n_dec;
    end
  end

  always_comb begin
    state_next = state;
    cell_ready = 1'b0;
    conv_start = 1'b0;
    conv_step  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.n_let = n_let_r;
    ctrl.n_dec = n_dec_r;
    unique case (state)
      caf_pkg::ST_IDLE: begin
        cell_ready = 1'b1;
        if (cell_valid) begin
          state_next = caf_pkg::ST_PREP;
        end
      end
      caf_pkg::ST_PREP: begin
        conv_start = 1'b1;
        state_next = caf_pkg::ST_CONV;
      end
      caf_pkg::ST_CONV: begin
        conv_step = 1'b1;
        if (cnt == CNT_W'(caf_pkg::CONV_W - 1)) begin
          state_next = caf_pkg::ST_LOAD;
        end
      end
      caf_pkg::ST_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = caf_pkg::ST_EMIT;
      end
      caf_pkg::ST_EMIT: begin
        if (!emit_active) begin
          state_next = caf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = caf_pkg::ST_IDLE;
      end
    endcase
  end

  caf_radix_conv #(
    .RADIX (caf_pkg::ALPHA),
    .NDIG  (caf_pkg::LET_DIGITS),
    .DW    (caf_pkg::LET_W),
    .IW    (caf_pkg::CONV_W)
  ) u_col_conv (
    .clk    (clk),
    .start  (conv_start),
    .step   (conv_step),
    .src    (caf_pkg::CONV_W'(col_v)),
    .digits (letters)
  );

  caf_radix_conv #(
    .RADIX (caf_pkg::RADIX),
    .NDIG  (caf_pkg::DEC_DIGITS),
    .DW    (caf_pkg::DEC_W),
    .IW    (caf_pkg::CONV_W)
  ) u_row_conv (
    .clk    (clk),
    .start  (conv_start),
    .step   (conv_step),
    .src    (caf_pkg::CONV_W'(row_c)),
    .digits (decimals)
  );

  caf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .letters    (letters),
    .decimals   (decimals),
    .row_c      (row_c),
    .col_c      (col_c),
    .active     (emit_active),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .addr       (addr)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && cell_ready) |=> !cell_ready)
    else $error("input beat taken while an item is in flight");

  a_emit_in_state: assert property (@(posedge clk) disable iff (rst)
    emit_active |-> (state == caf_pkg::ST_EMIT))
    else $error("serialiser busy outside the emit phase");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    addr_valid |-> (addr.address_char >= caf_pkg::CHAR_W'(caf_pkg::DIGIT_BASE)) &&
                   (addr.address_char <= caf_pkg::CHAR_W'(caf_pkg::LETTER_BASE +
                                                          caf_pkg::ALPHA)))
    else $error("address character out of range");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    addr_valid |-> (addr.row_used != '0) && (addr.column_used != '0) &&
                   (addr.row_used <= caf_pkg::ROW_W'(caf_pkg::MAX_ROWS)) &&
                   (addr.column_used <= caf_pkg::COL_W'(caf_pkg::MAX_COLS)))
    else $error("row or column outside the sheet limits");

endmodule

`default_nettype wire

/* rtl/caf_radix_conv.sv */
// ----------------------------------------------------------------------------
// caf_radix_conv
// Bit-serial binary to radix-N converter: one source bit enters per cycle while
// step is high, MSB first, and rides a carry chain through the digit register.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_radix_conv #(
  parameter int RADIX = caf_pkg::RADIX,
  parameter int NDIG  = caf_pkg::DEC_DIGITS,
  parameter int DW    = caf_pkg::DEC_W,
  parameter int IW    = caf_pkg::CONV_W
) (
  input  wire logic                 clk,
  input  wire logic                 start,
  input  wire logic                 step,
  input  wire logic [IW-1:0]        src,
  output logic      [NDIG*DW-1:0]   digits
);

  localparam logic [DW:0] RAD = (DW+1)'(RADIX);

  logic [IW-1:0]      sh;
  logic [NDIG*DW-1:0] digits_next;

  always_comb begin
    logic          carry;
    logic [DW:0]   t;
    carry = sh[IW-1];
    digits_next = '0;
    for (int i = 0; i < NDIG; i++) begin
      t = {digits[i*DW +: DW], carry};
      if (t >= RAD) begin
        t = t - RAD;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      digits_next[i*DW +: DW] = t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh     <= src;
      digits <= '0;
    end else if (step) begin
      sh     <= sh << 1;
      digits <= digits_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/caf_emit.sv */
// ----------------------------------------------------------------------------
// caf_emit
// Character serialiser: shifts letters then decimal digits out one per
// beat into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module caf_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire caf_pkg::emit_ctrl_t         ctrl,
  input  wire logic [caf_pkg::LET_VW-1:0]  letters,
  input  wire logic [caf_pkg::DEC_VW-1:0]  decimals,
  input  wire logic [caf_pkg::ROW_W-1:0]   row_c,
  input  wire logic [caf_pkg::COL_W-1:0]   col_c,
  output logic                             active,
  output logic                             addr_valid,
  input  wire logic                        addr_ready,
  output caf_pkg::addr_t                   addr
);

  logic [caf_pkg::NLET_W-1:0] let_cnt;
  logic [caf_pkg::NDEC_W-1:0] dec_cnt;
  logic [caf_pkg::LET_VW-1:0] let_sh;
  logic [caf_pkg::DEC_VW-1:0] dec_sh;
  logic                       take;
  caf_pkg::addr_t             addr_next;

  always_comb begin
    active = (let_cnt != '0) || (dec_cnt != '0);
    take   = active && (!addr_valid || addr_ready);
    addr_next.row_used    = row_c;
    addr_next.column_used = col_c;
    addr_next.last_char   = (let_cnt == '0) && (dec_cnt == caf_pkg::NDEC_W'(1));
    if (let_cnt != '0) begin
      addr_next.address_char =
        caf_pkg::CHAR_W'(let_sh[caf_pkg::LET_VW-1 -: caf_pkg::LET_W]) +
        caf_pkg::CHAR_W'(caf_pkg::LETTER_BASE + 1);
    end else begin
      addr_next.address_char =
        caf_pkg::CHAR_W'(dec_sh[caf_pkg::DEC_VW-1 -: caf_pkg::DEC_W]) +
        caf_pkg::CHAR_W'(caf_pkg::DIGIT_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      let_cnt    <= '0;
      dec_cnt    <= '0;
      addr_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        let_cnt <= ctrl.n_let;
        dec_cnt <= ctrl.n_dec;
      end else if (take) begin
        if (let_cnt != '0) begin
          let_cnt <= let_cnt - caf_pkg::NLET_W'(1);
        end else begin
          dec_cnt <= dec_cnt - caf_pkg::NDEC_W'(1);
        end
      end
      if (take) begin
        addr_valid <= 1'b1;
      end else if (addr_ready) begin
        addr_valid <= 1'b0;
      end
    end
  end

  // leading digit aligned to the top of each shift register on load
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      let_sh <= letters << (caf_pkg::LET_W * (caf_pkg::LET_DIGITS - int'(ctrl.n_let)));
      dec_sh <= decimals << (caf_pkg::DEC_W * (caf_pkg::DEC_DIGITS - int'(ctrl.n_dec)));
    end else if (take) begin
      addr <= addr_next;
      if (let_cnt != '0) begin
        let_sh <= let_sh << caf_pkg::LET_W;
      end else begin
        dec_sh <= dec_sh << caf_pkg::DEC_W;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cell address formatter. Row/column pairs go in
// over a valid/ready handshake; a scoreboard predicts the clamped row and
// column and the A1 address text, and every output beat is compared against
// it. The bench runs directed corners, then random pairs under three
// handshake idling mixes, with a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int RANDOM_CELLS = 408;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  class addr_scoreboard;
    caf_pkg::addr_t pending_chars[$];
    int    errors;
    int    addresses;
    int    chars_seen;

    function void note_cell(caf_pkg::cell_t c);
      int unsigned row;
      int unsigned col;
      int unsigned v;
      int unsigned r;
      logic [caf_pkg::CHAR_W-1:0] text[$];
      logic [caf_pkg::CHAR_W-1:0] digs[$];
      caf_pkg::addr_t beat;

      row = c.row_number;
      col = c.column_number;
      if (row < 1) row = 1;
      else if (row > caf_pkg::MAX_ROWS) row = caf_pkg::MAX_ROWS;
      if (col < 1) col = 1;
      else if (col > caf_pkg::MAX_COLS) col = caf_pkg::MAX_COLS;

      // bijective base 26 column letters
      if (col <= caf_pkg::ALPHA) begin
        text.push_back(caf_pkg::CHAR_W'(col + caf_pkg::LETTER_BASE));
      end else if (col < caf_pkg::THREE_LETTERS) begin
        v = col - (caf_pkg::ALPHA + 1);
        text.push_back(caf_pkg::CHAR_W'(v / caf_pkg::ALPHA + caf_pkg::LETTER_BASE + 1));
        text.push_back(caf_pkg::CHAR_W'(v % caf_pkg::ALPHA + caf_pkg::LETTER_BASE + 1));
      end else begin
        v = col - caf_pkg::THREE_LETTERS;
        text.push_back(caf_pkg::CHAR_W'(v / (caf_pkg::ALPHA * caf_pkg::ALPHA) +
                                        caf_pkg::LETTER_BASE + 1));
        text.push_back(caf_pkg::CHAR_W'((v / caf_pkg::ALPHA) % caf_pkg::ALPHA +
                                        caf_pkg::LETTER_BASE + 1));
        text.push_back(caf_pkg::CHAR_W'(v % caf_pkg::ALPHA + caf_pkg::LETTER_BASE + 1));
      end

      r = row;
      while (r != 0) begin
        digs.push_front(caf_pkg::CHAR_W'(r % caf_pkg::RADIX + caf_pkg::DIGIT_BASE));
        r = r / caf_pkg::RADIX;
      end
      foreach (digs[i]) text.push_back(digs[i]);

      foreach (text[i]) begin
        beat.address_char = text[i];
        beat.last_char    = (i == text.size() - 1);
        beat.row_used     = caf_pkg::ROW_W'(row);
        beat.column_used  = caf_pkg::COL_W'(col);
        pending_chars.push_back(beat);
      end
      addresses++;
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_beat(caf_pkg::addr_t got);
      caf_pkg::addr_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %0d", $time,
                 got.address_char);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.address_char !== want.address_char)
        report("address_char", want.address_char, got.address_char);
      if (got.last_char !== want.last_char)
        report("last_char", want.last_char, got.last_char);
      if (got.row_used !== want.row_used)
        report("row_used", want.row_used, got.row_used);
      if (got.column_used !== want.column_used)
        report("column_used", want.column_used, got.column_used);
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cell_valid = 1'b0;
  logic           cell_ready;
  caf_pkg::cell_t cell_data = '0;
  logic           addr_valid;
  logic           addr_ready = 1'b0;
  caf_pkg::addr_t addr;

  addr_scoreboard sb;
  int  idle_phase = 0;
  int  send_idle = 15;
  int  recv_idle = 73;
  int  hold_left = 0;
  bit  pressure_done = 0;
  int  cycles = 0;

  cell_address_formatter i_dut (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_data  (cell_data),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .addr       (addr)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL cell_address_formatter");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (idle_phase == 2 && !pressure_done) begin
      hold_left     = HOLD_CYCLES;
      pressure_done = 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      addr_ready <= 1'b0;
    end else begin
      addr_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && addr_valid && addr_ready) sb.check_beat(addr);
  end

  task automatic send_cell(input caf_pkg::cell_t c);
    while ($urandom_range(99) < send_idle) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_data  <= c;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    sb.note_cell(c);
  endtask

  task automatic send_random_cell();
    caf_pkg::cell_t c;
    int unsigned d;
    d = $urandom_range(1, 7);
    case ($urandom_range(3))
      0: c.row_number = caf_pkg::IN_ROW_W'($urandom);
      1: c.row_number = caf_pkg::IN_ROW_W'($urandom_range(10 ** (d - 1), 10 ** d - 1));
      2: c.row_number = caf_pkg::IN_ROW_W'($urandom_range(0, 120));
      default: c.row_number = caf_pkg::IN_ROW_W'($urandom_range(caf_pkg::MAX_ROWS - 3,
                                                                caf_pkg::MAX_ROWS + 3));
    endcase
    case ($urandom_range(4))
      0: c.column_number = caf_pkg::IN_COL_W'($urandom);
      1: c.column_number = caf_pkg::IN_COL_W'($urandom_range(0, 30));
      2: c.column_number = caf_pkg::IN_COL_W'($urandom_range(caf_pkg::ALPHA * caf_pkg::ALPHA,
                                                             caf_pkg::THREE_LETTERS + 30));
      3: c.column_number = caf_pkg::IN_COL_W'($urandom_range(caf_pkg::MAX_COLS - 3,
                                                             caf_pkg::MAX_COLS + 3));
      default: c.column_number = caf_pkg::IN_COL_W'($urandom_range(1, caf_pkg::MAX_COLS));
    endcase
    send_cell(c);
  endtask

  initial begin
    sb = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners: clamping, letter-count boundaries, digit counts
    send_cell('{24'd0,        16'd0});
    send_cell('{24'd1,        16'd1});
    send_cell('{24'd9,        16'd26});
    send_cell('{24'd10,       16'd27});
    send_cell('{24'd99,       16'd52});
    send_cell('{24'd100,      16'd53});
    send_cell('{24'd999,      16'd702});
    send_cell('{24'd1000,     16'd703});
    send_cell('{24'd9999,     16'd704});
    send_cell('{24'd10000,    16'd1378});
    send_cell('{24'd99999,    16'd1379});
    send_cell('{24'd100000,   16'd16383});
    send_cell('{24'd999999,   16'd16384});
    send_cell('{24'd1048575,  16'd16385});
    send_cell('{24'd1048576,  16'hFFFF});
    send_cell('{24'd1048577,  16'd18278});
    send_cell('{24'hFFFFFF,   16'd12345});
    send_cell('{24'h800000,   16'h8000});
    send_cell('{24'h555555,   16'hAAAA});
    send_cell('{24'hAAAAAA,   16'h5555});
    send_cell('{24'd123456,   16'd28});
    send_cell('{24'd7,        16'd677});

    for (int p = 0; p < 3; p++) begin
      idle_phase = p;
      send_idle  = (p == 0) ? 15 : (p == 1) ? 73 : 0;
      recv_idle  = (p == 0) ? 73 : (p == 1) ? 15 : 0;
      for (int i = 0; i < RANDOM_CELLS / 3 + 1; i++) send_random_cell();
    end
    cell_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d addresses formatted, %0d beats checked, %0d mismatches", sb.addresses,
             sb.chars_seen, sb.errors);
    $display("covered clamping, 1-3 letter columns, 1-7 digit rows and output backpressure");
    if (sb.errors == 0)
      $display("PASS cell_address_formatter");
    else
      $display("FAIL cell_address_formatter");
    $finish;
  end

endmodule
